// File: rtl/core/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

   localparam int SEQ_BITS_DEFAULT     = 8;
   localparam int BUFFER_DEPTH_DEFAULT = 16;

   localparam int WIN_W        = 5;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int ACTION_W     = 2;
   localparam int EVENT_W      = 3;
   localparam int REQ_DATA_W   = 80;
   localparam int RSP_DATA_W   = 104;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd4;

   localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

   localparam logic [ACTION_W-1:0] ACT_SEND    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ACK     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TIMEOUT = 2'd2;

   localparam logic [EVENT_W-1:0] EV_SENT       = 3'd0;
   localparam logic [EVENT_W-1:0] EV_REFUSED    = 3'd1;
   localparam logic [EVENT_W-1:0] EV_ACK_OK     = 3'd2;
   localparam logic [EVENT_W-1:0] EV_ACK_STALE  = 3'd3;
   localparam logic [EVENT_W-1:0] EV_ACK_BAD    = 3'd4;
   localparam logic [EVENT_W-1:0] EV_RETX       = 3'd5;
   localparam logic [EVENT_W-1:0] EV_TO_STALE   = 3'd6;

   typedef struct packed {
      logic [6:0]  pad;
      logic [63:0] payload;
      logic        checksum_ok;
      logic [7:0]  seq;
   } req_data_type;

   typedef struct packed {
      logic [4:0]  pad;
      logic [7:0]  next_seq;
      logic [7:0]  window_base;
      logic [7:0]  timer_seq;
      logic        timer_stop;
      logic        timer_start;
      logic [63:0] tx_payload;
      logic [7:0]  tx_seq;
      logic        tx_valid;
   } rsp_data_type;

endpackage

// File: rtl/core/srsw_ram.sv
// ----------------------------------------------------------------------------
// srsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srsw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/srsw_slot_unit.sv
// ----------------------------------------------------------------------------
// srsw_slot_unit
// Maps a sequence number to its buffer slot by a reciprocal multiplication in
// two register stages: quotient first, then the remainder.
// ----------------------------------------------------------------------------
module srsw_slot_unit #(
   parameter int SEQ_BITS     = srsw_pkg::SEQ_BITS_DEFAULT,
   parameter int BUFFER_DEPTH = srsw_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SEQ_BITS-1:0] value,
   output logic                done,
   output logic [((BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1)-1:0] slot
);

   localparam int SLOT_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int REM_W   = SLOT_W + 1;
   localparam int SHIFT   = SEQ_BITS + SLOT_W;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = SEQ_BITS + RECIP_W;
   localparam int QD_W    = SEQ_BITS + REM_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << SHIFT) + BUFFER_DEPTH - 1) / BUFFER_DEPTH);
   localparam logic [REM_W-1:0]   DEPTH_R = REM_W'(BUFFER_DEPTH);

   logic [SEQ_BITS-1:0] val_ff, val_in;
   logic [SEQ_BITS-1:0] quo_ff, quo_in;
   logic [SLOT_W-1:0]   rem_ff, rem_in;
   logic                mul_ff, mul_in;
   logic                sub_ff, sub_in;
   logic                done_ff, done_in;
   logic [PROD_W-1:0]   product;
   logic [QD_W-1:0]     multiple;
   logic [SEQ_BITS-1:0] diff;

   always_comb begin
      product  = PROD_W'(val_ff) * PROD_W'(RECIP);
      multiple = QD_W'(quo_ff) * QD_W'(DEPTH_R);
      diff     = val_ff - multiple[SEQ_BITS-1:0];
      val_in   = val_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      mul_in   = 1'b0;
      sub_in   = 1'b0;
      done_in  = 1'b0;
      if (start) begin
         val_in = value;
         mul_in = 1'b1;
      end
      if (mul_ff) begin
         quo_in = product[SHIFT +: SEQ_BITS];
         sub_in = 1'b1;
      end
      if (sub_ff) begin
         rem_in  = diff[SLOT_W-1:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         sub_ff  <= sub_in;
         done_ff <= done_in;
      end
      val_ff <= val_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign slot = rem_ff;

endmodule

// File: rtl/core/selective_repeat_sender_window.sv
// Flow: send, refused, corrupt and stale items go from the idle state straight to the
// result state; a timeout in the window passes the slot computation and the payload
// load, and an accepted ack the slot computation, the ack mark and a slide of the base
// over n slots (at most BUFFER_DEPTH). One item is in work at a time.
// Reset: synchronous; base and next sequence are 1, acked flags clear, window size 4.
// The payload buffer holds no reset value and is read only after it was written.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender window of a selective repeat ARQ with payload buffer and ack bitmap.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window #(
   parameter int SEQ_BITS     = srsw_pkg::SEQ_BITS_DEFAULT,
   parameter int BUFFER_DEPTH = srsw_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // seq [7:0], checksum_ok [8], payload [72:9], zero fill [79:73].
   input  logic [srsw_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action [1:0].
   input  logic [srsw_pkg::ACTION_W-1:0]      req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tx_valid [0], tx_seq [8:1], tx_payload [72:9], timer_start [73],
   // timer_stop [74], timer_seq [82:75], window_base [90:83], next_seq [98:91],
   // zero fill [103:99].
   output logic [srsw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // event_res [2:0].
   output logic [srsw_pkg::EVENT_W-1:0]       rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [srsw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [srsw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [srsw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int SLOT_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
   localparam int WIN_W  = srsw_pkg::WIN_W;
   localparam int CMP_W  = (SEQ_BITS > WIN_W) ? SEQ_BITS : WIN_W;
   localparam int CAP    = (BUFFER_DEPTH < (1 << SEQ_BITS) - 1) ?
                           BUFFER_DEPTH : (1 << SEQ_BITS) - 1;
   localparam logic [WIN_W-1:0]    CAP_W      = WIN_W'(CAP);
   localparam logic [WIN_W-1:0]    WIN_ONE    = WIN_W'(1);
   localparam logic [SEQ_BITS-1:0] SEQ_ONE    = SEQ_BITS'(1);
   localparam logic [SEQ_BITS-1:0] SEQ_TOP    = '1;
   localparam logic [SLOT_W-1:0]   SLOT_LAST  = SLOT_W'(BUFFER_DEPTH - 1);
   localparam logic [SLOT_W-1:0]   SLOT_ONE   = SLOT_W'(1);
   localparam logic [SLOT_W-1:0]   SLOT_RESET = SLOT_W'(1 % BUFFER_DEPTH);
   localparam logic [CNT_W-1:0]    CNT_DEPTH  = CNT_W'(BUFFER_DEPTH);
   localparam logic [CNT_W-1:0]    CNT_ONE    = CNT_W'(1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MOD   = 6'b000010,
      ST_ACK   = 6'b000100,
      ST_SLIDE = 6'b001000,
      ST_LOAD  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   function automatic logic [SLOT_W-1:0] slot_step(input logic [SEQ_BITS-1:0] s,
                                                    input logic [SLOT_W-1:0]   sl);
      if (s == SEQ_TOP) begin
         return '0;
      end else if (sl == SLOT_LAST) begin
         return '0;
      end
      return sl + SLOT_ONE;
   endfunction

   state_type                       state_ff, state_in;
   logic [WIN_W-1:0]                window_ff, window_in;
   logic [SEQ_BITS-1:0]             base_ff, base_in;
   logic [SEQ_BITS-1:0]             next_ff, next_in;
   logic [SLOT_W-1:0]               base_slot_ff, base_slot_in;
   logic [SLOT_W-1:0]               next_slot_ff, next_slot_in;
   logic [BUFFER_DEPTH-1:0]         acked_ff, acked_in;
   logic [srsw_pkg::ACTION_W-1:0]   act_ff, act_in;
   logic [SEQ_BITS-1:0]             seq_ff, seq_in;
   logic [CNT_W-1:0]                slide_cnt_ff, slide_cnt_in;
   logic [srsw_pkg::EVENT_W-1:0]    res_ev_ff, res_ev_in;
   srsw_pkg::rsp_data_type          res_ff, res_in;
   logic [srsw_pkg::EVENT_W-1:0]    rsp_ev_ff, rsp_ev_in;
   srsw_pkg::rsp_data_type          rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   srsw_pkg::req_data_type          req_data;
   logic [SEQ_BITS-1:0]             req_seq;
   logic                            req_fire;
   logic                            csr_wr;
   logic [WIN_W-1:0]                eff_w;
   logic [SEQ_BITS-1:0]             outstanding;
   logic [SEQ_BITS-1:0]             req_dist;
   logic                            win_full;
   logic                            in_window;
   logic                            slot_start;
   logic                            slot_done;
   logic [SLOT_W-1:0]               slot_val;
   logic                            ram_wr_en;
   logic                            ram_rd_en;
   logic [63:0]                     ram_rd_data;

   assign req_data    = srsw_pkg::req_data_type'(req_tdata);
   assign req_seq     = req_data.seq[SEQ_BITS-1:0];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign csr_pready  = 1'b1;
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata  = (csr_paddr[2] == srsw_pkg::REG_WINDOW_SIZE) ?
                        srsw_pkg::CSR_DATA_W'(window_ff) : '0;

   always_comb begin
      if (window_ff == '0) begin
         eff_w = WIN_ONE;
      end else if (window_ff > CAP_W) begin
         eff_w = CAP_W;
      end else begin
         eff_w = window_ff;
      end
      outstanding = next_ff - base_ff;
      req_dist    = req_seq - base_ff;
      win_full    = CMP_W'(outstanding) >= CMP_W'(eff_w);
      in_window   = (CMP_W'(req_dist) < CMP_W'(eff_w)) && (req_dist < outstanding);
   end

   srsw_slot_unit #(
      .SEQ_BITS     (SEQ_BITS),
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_slot_unit (
      .clock (clock),
      .reset (reset),
      .start (slot_start),
      .value (req_seq),
      .done  (slot_done),
      .slot  (slot_val)
   );

   srsw_ram #(
      .WIDTH (64),
      .DEPTH (BUFFER_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (next_slot_ff),
      .wr_data (req_data.payload),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_val),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      base_slot_in = base_slot_ff;
      next_slot_in = next_slot_ff;
      acked_in     = acked_ff;
      act_in       = act_ff;
      seq_in       = seq_ff;
      slide_cnt_in = slide_cnt_ff;
      res_ev_in    = res_ev_ff;
      res_in       = res_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      slot_start   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      if (csr_wr && (csr_paddr[2] == srsw_pkg::REG_WINDOW_SIZE)) begin
         window_in = csr_pwdata[WIN_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               act_in    = req_tuser;
               seq_in    = req_seq;
               res_in    = '0;
               res_ev_in = srsw_pkg::EV_ACK_STALE;
               state_in  = ST_DONE;
               case (req_tuser)
                  srsw_pkg::ACT_SEND: begin
                     if (win_full) begin
                        res_ev_in = srsw_pkg::EV_REFUSED;
                     end else begin
                        ram_wr_en          = 1'b1;
                        res_ev_in          = srsw_pkg::EV_SENT;
                        res_in.tx_valid    = 1'b1;
                        res_in.tx_seq      = 8'(next_ff);
                        res_in.tx_payload  = req_data.payload;
                        res_in.timer_start = 1'b1;
                        res_in.timer_seq   = 8'(next_ff);
                        next_in            = next_ff + SEQ_ONE;
                        next_slot_in       = slot_step(next_ff, next_slot_ff);
                     end
                  end
                  srsw_pkg::ACT_ACK: begin
                     if (!req_data.checksum_ok) begin
                        res_ev_in = srsw_pkg::EV_ACK_BAD;
                     end else if (in_window) begin
                        res_ev_in  = srsw_pkg::EV_ACK_OK;
                        slot_start = 1'b1;
                        state_in   = ST_MOD;
                     end
                  end
                  srsw_pkg::ACT_TIMEOUT: begin
                     res_in.timer_stop = 1'b1;
                     res_in.timer_seq  = 8'(req_seq);
                     if (in_window) begin
                        res_ev_in          = srsw_pkg::EV_RETX;
                        res_in.timer_start = 1'b1;
                        res_in.tx_valid    = 1'b1;
                        res_in.tx_seq      = 8'(req_seq);
                        slot_start         = 1'b1;
                        state_in           = ST_MOD;
                     end else begin
                        res_ev_in = srsw_pkg::EV_TO_STALE;
                     end
                  end
                  default: begin
                     res_ev_in = srsw_pkg::EV_ACK_STALE;
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (slot_done) begin
               if (act_ff == srsw_pkg::ACT_ACK) begin
                  state_in = ST_ACK;
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = ST_LOAD;
               end
            end
         end
         ST_ACK: begin
            if (!acked_ff[slot_val]) begin
               acked_in[slot_val] = 1'b1;
               res_in.timer_stop  = 1'b1;
               res_in.timer_seq   = 8'(seq_ff);
            end
            slide_cnt_in = '0;
            state_in     = ST_SLIDE;
         end
         ST_SLIDE: begin
            if ((slide_cnt_ff < CNT_DEPTH) && acked_ff[base_slot_ff]) begin
               acked_in[base_slot_ff] = 1'b0;
               base_in                = base_ff + SEQ_ONE;
               base_slot_in           = slot_step(base_ff, base_slot_ff);
               slide_cnt_in           = slide_cnt_ff + CNT_ONE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LOAD: begin
            res_in.tx_payload = ram_rd_data;
            state_in          = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_ev_in          = res_ev_ff;
               rsp_in             = res_ff;
               rsp_in.window_base = 8'(base_ff);
               rsp_in.next_seq    = 8'(next_ff);
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= srsw_pkg::WINDOW_RESET;
         base_ff      <= SEQ_ONE;
         next_ff      <= SEQ_ONE;
         base_slot_ff <= SLOT_RESET;
         next_slot_ff <= SLOT_RESET;
         acked_ff     <= '0;
         slide_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         base_slot_ff <= base_slot_in;
         next_slot_ff <= next_slot_in;
         acked_ff     <= acked_in;
         slide_cnt_ff <= slide_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff    <= act_in;
      seq_ff    <= seq_in;
      res_ev_ff <= res_ev_in;
      res_ff    <= res_in;
      rsp_ev_ff <= rsp_ev_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rsp_tuser  = rsp_ev_ff;

`ifndef NO_ASSERTIONS
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(outstanding) <= CMP_W'(CAP))
      else $error("outstanding count exceeds the window capacity");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("a second transfer was taken while an item was in work");

   a_slot_done: assert property (@(posedge clock) disable iff (reset)
      slot_done |-> (state_ff == ST_MOD))
      else $error("slot unit finished outside of the slot computation");
`endif

endmodule

// File: dv/selective_repeat_sender_window_tb.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_tb
// Drives send, acknowledgement and timeout requests into the sender window and
// checks every result against a cycle-free model of the window state, under
// random sender gaps and receiver stalls and several window size settings.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srsw_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_PER_PHASE = 317;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      rsp_data_type       fields;
   } window_outcome_type;

   class sender_window_tracker;
      logic [WIN_W-1:0]   window_reg;
      logic [7:0]         base_seq;
      logic [7:0]         next_seq;
      logic               acked [BUFFER_DEPTH_DEFAULT];
      logic [63:0]        stored_payload [BUFFER_DEPTH_DEFAULT];
      window_outcome_type expected_outcomes [$];
      int                 errors;

      function new();
         window_reg = WINDOW_RESET;
         base_seq = 8'd1;
         next_seq = 8'd1;
         foreach (acked[i]) acked[i] = 1'b0;
         foreach (stored_payload[i]) stored_payload[i] = '0;
         errors = 0;
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction

      function int unsigned window_limit();
         int unsigned w;
         w = window_reg;
         if (w < 1) w = 1;
         if (w > BUFFER_DEPTH_DEFAULT) w = BUFFER_DEPTH_DEFAULT;
         return w;
      endfunction

      function void note_request(logic [ACTION_W-1:0] action, req_data_type d);
         window_outcome_type o;
         int unsigned        w;
         logic [7:0]         in_flight;
         logic [7:0]         offset;
         logic [3:0]         slot;
         w = window_limit();
         in_flight = next_seq - base_seq;
         offset = d.seq - base_seq;
         slot = d.seq[3:0];
         o = '0;
         o.event_res = EV_ACK_STALE;
         case (action)
            ACT_SEND: begin
               if (in_flight >= w) begin
                  o.event_res = EV_REFUSED;
               end else begin
                  stored_payload[next_seq[3:0]] = d.payload;
                  o.event_res = EV_SENT;
                  o.fields.tx_valid = 1'b1;
                  o.fields.tx_seq = next_seq;
                  o.fields.tx_payload = d.payload;
                  o.fields.timer_start = 1'b1;
                  o.fields.timer_seq = next_seq;
                  next_seq = next_seq + 8'd1;
               end
            end
            ACT_ACK: begin
               if (!d.checksum_ok) begin
                  o.event_res = EV_ACK_BAD;
               end else if (offset < w && offset < in_flight) begin
                  o.event_res = EV_ACK_OK;
                  if (!acked[slot]) begin
                     acked[slot] = 1'b1;
                     o.fields.timer_stop = 1'b1;
                     o.fields.timer_seq = d.seq;
                  end
                  for (int i = 0; i < BUFFER_DEPTH_DEFAULT && acked[base_seq[3:0]]; i++) begin
                     acked[base_seq[3:0]] = 1'b0;
                     base_seq = base_seq + 8'd1;
                  end
               end
            end
            ACT_TIMEOUT: begin
               o.fields.timer_stop = 1'b1;
               o.fields.timer_seq = d.seq;
               if (offset < w && offset < in_flight) begin
                  o.event_res = EV_RETX;
                  o.fields.timer_start = 1'b1;
                  o.fields.tx_valid = 1'b1;
                  o.fields.tx_seq = d.seq;
                  o.fields.tx_payload = stored_payload[slot];
               end else begin
                  o.event_res = EV_TO_STALE;
               end
            end
            default: begin
            end
         endcase
         o.fields.window_base = base_seq;
         o.fields.next_seq = next_seq;
         expected_outcomes.push_back(o);
      endfunction

      function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
         if (act !== exp) begin
            $display("%0t: %s expected %h, actual %h", $time, name, exp, act);
            errors++;
         end
      endfunction

      function void check_response(logic [EVENT_W-1:0] ev, rsp_data_type d);
         window_outcome_type e;
         if (expected_outcomes.size() == 0) begin
            $display("%0t: result transfer with nothing expected, event %0d", $time, ev);
            errors++;
            return;
         end
         e = expected_outcomes.pop_front();
         compare_field("event_res", e.event_res, ev);
         compare_field("tx_valid", e.fields.tx_valid, d.tx_valid);
         compare_field("tx_seq", e.fields.tx_seq, d.tx_seq);
         compare_field("tx_payload", e.fields.tx_payload, d.tx_payload);
         compare_field("timer_start", e.fields.timer_start, d.timer_start);
         compare_field("timer_stop", e.fields.timer_stop, d.timer_stop);
         compare_field("timer_seq", e.fields.timer_seq, d.timer_seq);
         compare_field("window_base", e.fields.window_base, d.window_base);
         compare_field("next_seq", e.fields.next_seq, d.next_seq);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACTION_W-1:0]   req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [EVENT_W-1:0]    rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sender_window_tracker tracker = new();
   int unsigned          sender_idle_pct = 0;
   int unsigned          receiver_stall_pct = 0;
   int unsigned          quiet_cycles = 0;

   selective_repeat_sender_window u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_response(rsp_tuser, rsp_data_type'(rsp_tdata));
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("selective_repeat_sender_window verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic drive_request(logic [ACTION_W-1:0] action, logic [7:0] seq, logic ck,
                                logic [63:0] payload);
      req_data_type d;
      d = '0;
      d.seq = seq;
      d.checksum_ok = ck;
      d.payload = payload;
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= action;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_request(action, d);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic write_window_size(logic [WIN_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({REG_WINDOW_SIZE, 2'b00});
      csr_pwdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.window_reg = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic drive_random_item();
      logic [ACTION_W-1:0] action;
      logic [7:0]          seq;
      logic                ck;
      logic [63:0]         payload;
      logic [7:0]          in_flight;
      int unsigned         r;
      r = $urandom_range(0, 99);
      in_flight = tracker.next_seq - tracker.base_seq;
      seq = 8'($urandom_range(0, 255));
      ck = 1'($urandom_range(0, 1));
      payload = {$urandom, $urandom};
      if (r < 40) begin
         action = ACT_SEND;
      end else if (r < 66) begin
         action = ACT_ACK;
         ck = 1'b1;
         if (in_flight != 0) begin
            if ($urandom_range(0, 1) == 0) begin
               seq = tracker.base_seq;
            end else begin
               seq = tracker.base_seq + 8'($urandom_range(0, in_flight - 1));
            end
         end
      end else if (r < 72) begin
         action = ACT_ACK;
         ck = 1'b0;
      end else if (r < 77) begin
         action = ACT_ACK;
         ck = 1'b1;
      end else if (r < 90) begin
         action = ACT_TIMEOUT;
         if (in_flight != 0) begin
            seq = tracker.base_seq + 8'($urandom_range(0, in_flight - 1));
         end
      end else if (r < 97) begin
         action = ACT_TIMEOUT;
      end else begin
         action = ACT_NONE;
      end
      drive_request(action, seq, ck, payload);
   endtask

   initial begin
      logic [WIN_W-1:0] phase_windows [6];
      phase_windows = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd9, 5'd0};
      phase_windows[5] = WIN_W'($urandom_range(0, 31));
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The window starts at its reset size of four: fill it, then exercise
      // refusal, timeouts, and corrupt, stale, duplicate and out-of-order acknowledgements.
      drive_request(ACT_SEND, 8'h00, 1'b0, 64'h0);
      drive_request(ACT_SEND, 8'hFF, 1'b1, {64{1'b1}});
      drive_request(ACT_SEND, 8'h5A, 1'b0, {$urandom, $urandom});
      drive_request(ACT_SEND, 8'hA5, 1'b1, {$urandom, $urandom});
      drive_request(ACT_SEND, 8'h00, 1'b0, {$urandom, $urandom});
      drive_request(ACT_ACK, 8'd3, 1'b0, 64'h0);
      drive_request(ACT_ACK, 8'd9, 1'b1, 64'h0);
      drive_request(ACT_ACK, 8'd3, 1'b1, 64'h0);
      drive_request(ACT_ACK, 8'd3, 1'b1, {64{1'b1}});
      drive_request(ACT_TIMEOUT, 8'd2, 1'b0, 64'h0);
      drive_request(ACT_TIMEOUT, 8'd200, 1'b1, 64'h0);
      drive_request(ACT_NONE, 8'hFF, 1'b1, {64{1'b1}});
      drive_request(ACT_ACK, 8'd1, 1'b1, 64'h0);
      drive_request(ACT_ACK, 8'd2, 1'b1, 64'h0);
      drive_request(ACT_ACK, 8'd4, 1'b1, 64'h0);
      drive_request(ACT_ACK, 8'd5, 1'b1, 64'h0);
      drive_request(ACT_TIMEOUT, 8'd5, 1'b0, 64'h0);

      // A window size of zero behaves as a window of one.
      wait_for_results();
      write_window_size(5'd0);
      drive_request(ACT_SEND, 8'h00, 1'b0, {$urandom, $urandom});
      drive_request(ACT_SEND, 8'h00, 1'b0, {$urandom, $urandom});
      drive_request(ACT_TIMEOUT, 8'd5, 1'b1, 64'h0);
      drive_request(ACT_ACK, 8'd5, 1'b1, 64'h0);

      for (int phase = 0; phase < 6; phase++) begin
         wait_for_results();
         case (phase / 2)
            0: begin
               sender_idle_pct = 16;
               receiver_stall_pct = 61;
            end
            1: begin
               sender_idle_pct = 61;
               receiver_stall_pct = 16;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
         endcase
         write_window_size(phase_windows[phase]);
         repeat (RANDOM_PER_PHASE) drive_random_item();
      end

      wait_for_results();
      repeat (40) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("selective_repeat_sender_window verification clean");
      end else begin
         $display("selective_repeat_sender_window verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/srsw_pkg.sv
rtl/core/srsw_ram.sv
rtl/core/srsw_slot_unit.sv
rtl/core/selective_repeat_sender_window.sv
dv/selective_repeat_sender_window_tb.sv
